/* hw/rtl/rwu_pkg.sv */
// ----------------------------------------------------------------------------
// rwu_pkg
// Shared types and constants for the resilient backprop weight update unit.
// ----------------------------------------------------------------------------
package rwu_pkg;

  // storage geometry
  localparam int ENTRY_COUNT = 1024;
  localparam int ADDR_W      = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int IDX_W       = 10;

  // field widths
  localparam int WEIGHT_W = 28;
  localparam int GRAD_W   = 32;
  localparam int STEP_W   = 27;
  localparam int INC_W    = 18;
  localparam int DEC_W    = 17;
  localparam int CFG_W    = 27;
  localparam int CFG_IDX_W = 3;
  localparam int SIGN_W   = 2;
  localparam int ENTRY_W  = STEP_W + SIGN_W;

  // arithmetic constants, Q16.16
  localparam logic [STEP_W-1:0] STEP_FLOOR   = STEP_W'(7);
  localparam logic [STEP_W-1:0] STEP_LIMIT   = STEP_W'(98304000);
  localparam int                WEIGHT_LIMIT = 98304000;
  localparam int                FRAC_W       = 16;
  localparam int                PROD_W       = STEP_W + INC_W;
  localparam int                SCALED_W     = PROD_W - FRAC_W;

  // register reset values
  localparam logic [INC_W-1:0]  INC_RESET  = INC_W'(78643);
  localparam logic [DEC_W-1:0]  DEC_RESET  = DEC_W'(32768);
  localparam logic [STEP_W-1:0] MIN_RESET  = STEP_W'(0);
  localparam logic [STEP_W-1:0] MAX_RESET  = STEP_W'(3276800);
  localparam logic [STEP_W-1:0] INIT_RESET = STEP_W'(6554);

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INCREASE = 3'd0,
    REG_DECREASE = 3'd1,
    REG_STEP_MIN = 3'd2,
    REG_STEP_MAX = 3'd3,
    REG_STEP_INIT = 3'd4
  } cfg_reg_t;

  // action codes
  localparam logic ACT_CLEAR  = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // stored sign codes
  typedef enum logic [SIGN_W-1:0] {
    SIGN_ZERO = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef struct packed {
    logic                        action;
    logic [IDX_W-1:0]            weight_index;
    logic signed [WEIGHT_W-1:0]  weight_in;
    logic signed [GRAD_W-1:0]    gradient;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]            result_index;
    logic signed [WEIGHT_W-1:0]  weight_out;
    logic [STEP_W-1:0]           step_out;
  } out_item_t;

  typedef struct packed {
    logic [INC_W-1:0]  grow_factor;
    logic [DEC_W-1:0]  shrink_factor;
    logic [STEP_W-1:0] step_min;
    logic [STEP_W-1:0] step_max;
    logic [STEP_W-1:0] step_initial;
  } cfg_t;

endpackage

/* hw/rtl/rwu_ram.sv */
// ----------------------------------------------------------------------------
// rwu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/rwu_update.sv */
// ----------------------------------------------------------------------------
// rwu_update
// Combinational step and weight update for one item, given the stored entry.
// ----------------------------------------------------------------------------
module rwu_update (
  input  rwu_pkg::in_item_t                item,
  input  rwu_pkg::cfg_t                    cfg,
  input  logic [rwu_pkg::STEP_W-1:0]       stored_step,
  input  logic [rwu_pkg::SIGN_W-1:0]       stored_sign,
  output logic [rwu_pkg::STEP_W-1:0]       new_step,
  output logic [rwu_pkg::SIGN_W-1:0]       new_sign,
  output rwu_pkg::out_item_t               result
);
  import rwu_pkg::*;

  localparam int WSUM_W = WEIGHT_W + 2;
  localparam logic signed [WSUM_W-1:0] W_HI = WSUM_W'(WEIGHT_LIMIT);
  localparam logic signed [WSUM_W-1:0] W_LO = -WSUM_W'(WEIGHT_LIMIT);

  sign_t                     prev;
  sign_t                     cur;
  sign_t                     kept;
  logic                      grow;
  logic [STEP_W-1:0]         floored;
  logic [INC_W-1:0]          factor;
  logic [PROD_W-1:0]         prod;
  logic [PROD_W-1:0]         rounded;
  logic [SCALED_W-1:0]       scaled;
  logic [SCALED_W-1:0]       bounded;
  logic [STEP_W-1:0]         upd_step;
  logic signed [WSUM_W-1:0]  wsum;
  logic signed [WSUM_W-1:0]  wclamp;

  // decode stored and new sign, unused code reads as zero
  always_comb begin
    unique case (stored_sign)
      SIGN_POS: prev = SIGN_POS;
      SIGN_NEG: prev = SIGN_NEG;
      default:  prev = SIGN_ZERO;
    endcase
    if (item.gradient > 0) begin
      cur = SIGN_POS;
    end else if (item.gradient < 0) begin
      cur = SIGN_NEG;
    end else begin
      cur = SIGN_ZERO;
    end
    grow = (prev == SIGN_ZERO) || (cur == SIGN_ZERO) || (prev == cur);
  end

  // scale the floored step by the selected factor, round half up
  always_comb begin
    floored = (stored_step < STEP_FLOOR) ? STEP_FLOOR : stored_step;
    factor  = grow ? cfg.grow_factor : INC_W'(cfg.shrink_factor);
    prod    = PROD_W'(floored) * PROD_W'(factor);
    rounded = prod + PROD_W'(32768);
    scaled  = rounded[PROD_W-1:FRAC_W];
  end

  // bound the scaled step
  always_comb begin
    if (grow) begin
      bounded = (scaled > SCALED_W'(cfg.step_max)) ? SCALED_W'(cfg.step_max) : scaled;
    end else begin
      bounded = (scaled < SCALED_W'(cfg.step_min)) ? SCALED_W'(cfg.step_min) : scaled;
    end
    upd_step = (bounded > SCALED_W'(STEP_LIMIT)) ? STEP_LIMIT : bounded[STEP_W-1:0];
    kept     = grow ? cur : SIGN_ZERO;
  end

  // move the weight, or just clamp it on a clear
  always_comb begin
    wsum = WSUM_W'(item.weight_in);
    if (item.action == ACT_CLEAR) begin
      new_step = (cfg.step_initial > STEP_LIMIT) ? STEP_LIMIT : cfg.step_initial;
      new_sign = SIGN_ZERO;
    end else begin
      new_step = upd_step;
      new_sign = kept;
      if (kept == SIGN_POS) begin
        wsum = WSUM_W'(item.weight_in) + $signed({3'b000, upd_step});
      end else if (kept == SIGN_NEG) begin
        wsum = WSUM_W'(item.weight_in) - $signed({3'b000, upd_step});
      end
    end
    if (wsum > W_HI) begin
      wclamp = W_HI;
    end else if (wsum < W_LO) begin
      wclamp = W_LO;
    end else begin
      wclamp = wsum;
    end
    result.result_index = item.weight_index;
    result.weight_out   = wclamp[WEIGHT_W-1:0];
    result.step_out     = new_step;
  end

endmodule

/* hw/rtl/rprop_weight_update_unit.sv */
// ----------------------------------------------------------------------------
// rprop_weight_update_unit
// Resilient backprop (iRprop-) weight update with per-weight step and sign
// storage, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_valid/in_ready, in_data) carry an action, an entry index,
//   the current weight and the gradient. A clear beat resets the entry's step
//   to step_initial and its sign to zero; an update beat adapts the step and
//   moves the weight. Each input beat yields exactly one output beat
//   (out_valid/out_ready, out_data) with the new weight and stored step.
//   The entry read is registered together with the beat when it is accepted,
//   and the update lands in the output register when the read stage
//   advances (s1_fire), which waits while the output register is full.
//   Throughput is one beat per cycle while out_ready stays high; back-to-back
//   beats to the same entry are served by a bypass of the last entry write.
//   After reset the sign store is swept to zero, one entry per cycle, over
//   all ENTRY_COUNT (1024) entries; in_ready stays low meanwhile. Register
//   writes (cfg_we, cfg_index, cfg_data) are taken at any time.
//   When the receiver stalls, the output register holds its beat, the stage
//   behind it fills, and in_ready drops after that.
// ----------------------------------------------------------------------------
module rprop_weight_update_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rwu_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rwu_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [rwu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rwu_pkg::CFG_W-1:0]         cfg_data
);
  import rwu_pkg::*;

  localparam int NUM_W = $clog2(ENTRY_COUNT + 1) + 1;

  cfg_t               cfg;
  logic               clearing;
  logic [ADDR_W-1:0]  clr_addr;
  logic               in_fire;
  logic               s1_valid;
  in_item_t           s1_item;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_fire;
  logic               out_free;
  logic [ADDR_W-1:0]  in_addr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               fwd_valid;
  logic [ADDR_W-1:0]  fwd_addr;
  logic [ENTRY_W-1:0] fwd_entry;
  logic [ENTRY_W-1:0] cur_entry;
  logic [STEP_W-1:0]  new_step;
  logic [SIGN_W-1:0]  new_sign;
  out_item_t          result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grow_factor   <= INC_RESET;
      cfg.shrink_factor <= DEC_RESET;
      cfg.step_min      <= MIN_RESET;
      cfg.step_max      <= MAX_RESET;
      cfg.step_initial  <= INIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INCREASE:  cfg.grow_factor   <= cfg_data[INC_W-1:0];
        REG_DECREASE:  cfg.shrink_factor <= cfg_data[DEC_W-1:0];
        REG_STEP_MIN:  cfg.step_min      <= cfg_data[STEP_W-1:0];
        REG_STEP_MAX:  cfg.step_max      <= cfg_data[STEP_W-1:0];
        REG_STEP_INIT: cfg.step_initial  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sign clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (NUM_W'(clr_addr) == NUM_W'(ENTRY_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // handshake
  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid && out_free;
  assign in_ready = !clearing && (!s1_valid || out_free);
  assign in_fire  = in_valid && in_ready;
  assign in_addr  = ADDR_W'(NUM_W'(in_data.weight_index) % NUM_W'(ENTRY_COUNT));

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_data;
      s1_addr <= in_addr;
    end
  end

  // entry store write mux: sweep first, then updates
  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s1_fire;
      ram_waddr = s1_addr;
      ram_wdata = {new_step, new_sign};
    end
  end

  rwu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRY_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // bypass of the most recent entry write
  always_ff @(posedge clk) begin
    if (rst || clearing) begin
      fwd_valid <= 1'b0;
    end else if (s1_fire) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_addr  <= s1_addr;
      fwd_entry <= {new_step, new_sign};
    end
  end

  assign cur_entry = (fwd_valid && fwd_addr == s1_addr) ? fwd_entry : ram_rdata;

  rwu_update u_update (
    .item        (s1_item),
    .cfg         (cfg),
    .stored_step (cur_entry[ENTRY_W-1:SIGN_W]),
    .stored_sign (cur_entry[SIGN_W-1:0]),
    .new_step    (new_step),
    .new_sign    (new_sign),
    .result      (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

endmodule

/* test/tb_rprop_weight_update_unit.sv */
// ----------------------------------------------------------------------------
// tb_rprop_weight_update_unit
// Self-checking bench for the iRprop- weight update unit. A queue of input
// beats, directed corner cases followed by random training-like sequences,
// feeds a valid/ready driver. A scoreboard predicts the new weight and step
// per beat from its own copy of the per-entry step/sign state and registers,
// and a monitor compares every output beat. Registers are changed between
// phases while the pipeline is empty, covering both range extremes.
// ----------------------------------------------------------------------------
module tb_rprop_weight_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rwu_pkg::*;

  localparam int NUM_PHASES       = 7;
  localparam int RANDOM_PER_PHASE = 224;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = 20;
  localparam int HOT_COUNT        = 8;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INCREASE;
  logic [CFG_W-1:0]  cfg_data  = '0;

  rprop_weight_update_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // scoreboard copy of the registers and per-entry state
  logic [INC_W-1:0]  sb_increase  = INC_RESET;
  logic [DEC_W-1:0]  sb_decrease  = DEC_RESET;
  logic [STEP_W-1:0] sb_step_min  = MIN_RESET;
  logic [STEP_W-1:0] sb_step_max  = MAX_RESET;
  logic [STEP_W-1:0] sb_step_init = INIT_RESET;
  logic [31:0]       entry_step [ENTRY_COUNT] = '{default: '0};
  sign_t             entry_sign [ENTRY_COUNT] = '{default: SIGN_ZERO};

  in_item_t  pending_beats [$];
  out_item_t expected_results [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // stimulus side bookkeeping: entries with a known step, preferred direction
  bit          gen_written [ENTRY_COUNT] = '{default: 1'b0};
  bit          gen_dir_neg [ENTRY_COUNT] = '{default: 1'b0};
  int unsigned hot_idx [HOT_COUNT];

  // new weight and step for one beat, advancing the scoreboard state
  function automatic out_item_t compute_update(in_item_t beat);
    out_item_t   res;
    int unsigned ent;
    longint      w;
    longint      step;
    longint      base;
    sign_t       prev;
    sign_t       cur;
    ent = beat.weight_index % ENTRY_COUNT;
    w = beat.weight_in;
    if (beat.action == ACT_CLEAR) begin
      step = sb_step_init;
      if (step > STEP_LIMIT) step = STEP_LIMIT;
      entry_sign[ent] = SIGN_ZERO;
    end else begin
      prev = entry_sign[ent];
      if (prev != SIGN_POS && prev != SIGN_NEG) prev = SIGN_ZERO;
      if (beat.gradient > 0) cur = SIGN_POS;
      else if (beat.gradient < 0) cur = SIGN_NEG;
      else cur = SIGN_ZERO;
      base = entry_step[ent];
      if (base < STEP_FLOOR) base = STEP_FLOOR;
      if (prev == SIGN_ZERO || cur == SIGN_ZERO || prev == cur) begin
        step = (base * longint'(sb_increase) + 32768) >> FRAC_W;
        if (step > sb_step_max) step = sb_step_max;
      end else begin
        // sign flip: shrink and forget this gradient
        step = (base * longint'(sb_decrease) + 32768) >> FRAC_W;
        if (step < sb_step_min) step = sb_step_min;
        cur = SIGN_ZERO;
      end
      if (step > STEP_LIMIT) step = STEP_LIMIT;
      if (cur == SIGN_POS) w = w + step;
      else if (cur == SIGN_NEG) w = w - step;
      entry_sign[ent] = cur;
    end
    entry_step[ent] = 32'(step);
    if (w > WEIGHT_LIMIT) w = WEIGHT_LIMIT;
    if (w < -WEIGHT_LIMIT) w = -WEIGHT_LIMIT;
    res.result_index = beat.weight_index;
    res.weight_out   = WEIGHT_W'(w);
    res.step_out     = STEP_W'(step);
    return res;
  endfunction

  function automatic int pause_len(bit calm);
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] rand_weight();
    int v;
    case ($urandom_range(0, 5))
      0: v = int'($urandom);
      1: v = WEIGHT_LIMIT - int'($urandom_range(0, 200000));
      2: v = -WEIGHT_LIMIT + int'($urandom_range(0, 200000));
      3: v = int'($urandom_range(0, 2000000)) - 1000000;
      4: v = $urandom_range(0, 1) ? WEIGHT_LIMIT : -WEIGHT_LIMIT;
      default: v = int'($urandom_range(0, 2 * WEIGHT_LIMIT)) - WEIGHT_LIMIT;
    endcase
    return WEIGHT_W'(v);
  endfunction

  function automatic logic signed [GRAD_W-1:0] rand_gradient(sign_t s);
    logic signed [GRAD_W-1:0] mag;
    case ($urandom_range(0, 3))
      0: mag = 1;
      1: mag = GRAD_W'($urandom_range(1, 65536));
      default: mag = GRAD_W'($urandom_range(1, 32'h7FFF_FFFF));
    endcase
    if (s == SIGN_ZERO) return '0;
    if (s == SIGN_POS) return mag;
    return ($urandom_range(0, 19) == 0) ? 32'sh8000_0000 : -mag;
  endfunction

  // queue one beat; an update of a never-stepped entry gets a clear first
  task automatic add_beat(logic act, logic [IDX_W-1:0] idx,
                          logic signed [WEIGHT_W-1:0] w, logic signed [GRAD_W-1:0] g);
    in_item_t b;
    if (act == ACT_UPDATE && !gen_written[idx % ENTRY_COUNT]) begin
      b.action       = ACT_CLEAR;
      b.weight_index = idx;
      b.weight_in    = rand_weight();
      b.gradient     = GRAD_W'($urandom);
      pending_beats.push_back(b);
    end
    b.action       = act;
    b.weight_index = idx;
    b.weight_in    = w;
    b.gradient     = g;
    pending_beats.push_back(b);
    gen_written[idx % ENTRY_COUNT] = 1'b1;
  endtask

  // mostly runs of updates on a few hot entries, some clears and some noise
  task automatic add_random_beat();
    int unsigned r;
    int unsigned idx;
    sign_t       s;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      add_beat(1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 1023)),
               WEIGHT_W'($urandom), GRAD_W'($urandom));
    end else begin
      idx = (r < 80) ? hot_idx[$urandom_range(0, HOT_COUNT - 1)]
                     : $urandom_range(0, ENTRY_COUNT - 1);
      if ($urandom_range(0, 99) < 6) begin
        add_beat(ACT_CLEAR, IDX_W'(idx), rand_weight(), GRAD_W'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) gen_dir_neg[idx] = ~gen_dir_neg[idx];
        r = $urandom_range(0, 99);
        if (r < 65) s = gen_dir_neg[idx] ? SIGN_NEG : SIGN_POS;
        else if (r < 80) s = SIGN_ZERO;
        else s = gen_dir_neg[idx] ? SIGN_POS : SIGN_NEG;
        add_beat(ACT_UPDATE, IDX_W'(idx), rand_weight(), rand_gradient(s));
      end
    end
  endtask

  // corner cases under the reset register values
  task automatic load_directed();
    add_beat(ACT_CLEAR,  10'd0,    28'sd0,              32'sd0);
    add_beat(ACT_CLEAR,  10'd1023, 28'sh7FF_FFFF,       32'sh7FFF_FFFF);
    add_beat(ACT_CLEAR,  10'd512,  28'sh800_0000,       32'sh8000_0000);
    add_beat(ACT_UPDATE, 10'd0,    28'sd0,              32'sd1);
    add_beat(ACT_UPDATE, 10'd0,    28'sd98304000,       32'sh7FFF_FFFF);
    add_beat(ACT_UPDATE, 10'd0,    28'sd98303990,       32'sh8000_0000);
    add_beat(ACT_UPDATE, 10'd0,    28'sd12345,          32'sd0);
    add_beat(ACT_UPDATE, 10'd0,    -28'sd98304000,      -32'sd1);
    add_beat(ACT_UPDATE, 10'd1023, 28'sh7FF_FFFF,       32'sd0);
    add_beat(ACT_UPDATE, 10'd1023, 28'sh800_0000,       32'sd5);
    add_beat(ACT_UPDATE, 10'd512,  -28'sd98304000,      -32'sd1);
    add_beat(ACT_UPDATE, 10'd512,  28'sd98304000,       32'sd1);
    add_beat(ACT_UPDATE, 10'd512,  28'sd0,              32'sd1);
    add_beat(ACT_UPDATE, 10'd512,  28'sd0,              -32'sd7);
    add_beat(ACT_UPDATE, 10'd512,  28'sd0,              -32'sd7);
    add_beat(ACT_CLEAR,  10'd0,    28'sd1,              -32'sd1);
    add_beat(ACT_UPDATE, 10'd0,    -28'sd1,             -32'sd1);
  endtask

  function automatic cfg_t phase_settings(int ph);
    cfg_t s;
    s.grow_factor   = INC_W'($urandom_range(65536, 131072));
    s.shrink_factor = DEC_W'($urandom_range(0, 65536));
    s.step_min      = STEP_W'($urandom_range(0, 98304000));
    s.step_max      = STEP_W'($urandom_range(0, 98304000));
    s.step_initial  = STEP_W'($urandom_range(0, 98304000));
    case (ph)
      1: begin
        // upper extremes, min equal to max
        s.grow_factor   = INC_W'(131072);
        s.shrink_factor = DEC_W'(65536);
        s.step_min      = STEP_LIMIT;
        s.step_max      = STEP_LIMIT;
        s.step_initial  = STEP_LIMIT;
      end
      2: begin
        // lower extremes, steps pinned to the floor path
        s.grow_factor   = INC_W'(65536);
        s.shrink_factor = DEC_W'(0);
        s.step_min      = '0;
        s.step_max      = '0;
        s.step_initial  = '0;
      end
      3: begin
        // shrink floor above growth cap
        s.step_min     = STEP_W'($urandom_range(1000000, 5000000));
        s.step_max     = STEP_W'($urandom_range(1000, 100000));
        s.step_initial = STEP_W'($urandom_range(0, 200000));
      end
      4: begin
        s.step_min     = STEP_W'($urandom_range(0, 2000));
        s.step_max     = STEP_W'($urandom_range(1000, 2000000));
        s.step_initial = STEP_W'($urandom_range(0, 500000));
      end
      6: begin
        // tiny steps, floor at or below the built-in minimum
        s.step_min     = STEP_W'($urandom_range(0, 7));
        s.step_max     = STEP_LIMIT;
        s.step_initial = STEP_W'($urandom_range(0, 20));
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    case (r)
      REG_INCREASE:  sb_increase  = v[INC_W-1:0];
      REG_DECREASE:  sb_decrease  = v[DEC_W-1:0];
      REG_STEP_MIN:  sb_step_min  = v[STEP_W-1:0];
      REG_STEP_MAX:  sb_step_max  = v[STEP_W-1:0];
      REG_STEP_INIT: sb_step_init = v[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_INCREASE,  CFG_W'(s.grow_factor));
    write_reg(REG_DECREASE,  CFG_W'(s.shrink_factor));
    write_reg(REG_STEP_MIN,  CFG_W'(s.step_min));
    write_reg(REG_STEP_MAX,  CFG_W'(s.step_max));
    write_reg(REG_STEP_INIT, CFG_W'(s.step_initial));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // input driver: one beat per pop, random gap after each accepted beat
  int gap_left = 0;
  bit send_calm = 1'b0;

  always @(posedge clk) begin : drive_beats
    int gap;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_results.push_back(compute_update(in_data));
        if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
        gap = pause_len(send_calm);
      end else begin
        gap = gap_left;
      end
      if (gap == 0 && pending_beats.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= pending_beats.pop_front();
        gap_left <= 0;
      end else begin
        in_valid <= 1'b0;
        gap_left <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  // output monitor with random back-pressure
  int stall_left = 0;
  bit recv_calm = 1'b0;

  always @(posedge clk) begin : check_beats
    int        st;
    out_item_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      st = stall_left;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected output beat for index %0d", out_data.result_index);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d",
                   want.result_index, out_data.result_index);
            mismatch_count++;
          end
          if (out_data.weight_out !== want.weight_out) begin
            $error("weight_out: expected %0d, got %0d", want.weight_out, out_data.weight_out);
            mismatch_count++;
          end
          if (out_data.step_out !== want.step_out) begin
            $error("step_out: expected %0d, got %0d", want.step_out, out_data.step_out);
            mismatch_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
        st = pause_len(recv_calm);
      end
      if (st == 0) begin
        out_ready  <= 1'b1;
        stall_left <= 0;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= st - 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rprop_weight_update_unit: mismatch");
      $finish;
    end
  end

  // reset, then phases of register settings with directed and random beats
  initial begin : stimulus
    int ph;
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) apply_settings(phase_settings(ph));
      else load_directed();
      for (n = 0; n < HOT_COUNT; n++) hot_idx[n] = $urandom_range(0, ENTRY_COUNT - 1);
      hot_idx[HOT_COUNT - 1] = (ph % 2) ? 0 : ENTRY_COUNT - 1;
      for (n = 0; n < RANDOM_PER_PHASE; n++) add_random_beat();
      wait_drained();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rprop_weight_update_unit: match");
    end else begin
      $display("rprop_weight_update_unit: mismatch");
    end
    $finish;
  end

endmodule
